/* src/temp_reading_to_ascii_digits_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the temperature-to-ASCII block
// Concurrent checks, removed when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TEMP_READING_TO_ASCII_DIGITS_ASSERT_SVH
`define TEMP_READING_TO_ASCII_DIGITS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TRTAD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TRTAD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRTAD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TRTAD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/trtad_pkg.sv */
// ----------------------------------------------------------------------------
// trtad_pkg
// Types and constants shared by the temperature-to-ASCII block.
// ----------------------------------------------------------------------------
package trtad_pkg;

    localparam int RAW_W        = 16;
    localparam int HUND_W       = 13;   // hundredths of a degree, <= 6375
    localparam int X9_W         = 16;   // hundredths * 9, <= 57375
    localparam int PROD_W       = 32;
    localparam int RECIP5_SHIFT = 18;
    localparam int DISP_W       = 14;   // displayed value, <= 14675
    localparam int BCD_DIGITS   = 5;
    localparam int BCD_W        = 4 * BCD_DIGITS;
    localparam int NUM_CELLS    = DISP_W;

    // floor(x / 5) = (x * 52429) >> 18 for any x below 2^18
    localparam logic [X9_W-1:0]   RECIP5      = 16'd52429;
    localparam logic [DISP_W-1:0] FAHR_OFFSET = 14'd3200;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    // one word in flight through the conversion chain
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [BCD_W-1:0]  bcd;
        logic [DISP_W-1:0] bin;
    } cell_t;

endpackage

/* src/trtad_front.sv */
// ----------------------------------------------------------------------------
// trtad_front
// Magnitude, hundredths scaling and Fahrenheit conversion, two stages.
// ----------------------------------------------------------------------------
module trtad_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [trtad_pkg::RAW_W-1:0]     raw_reading,
    input  logic                            fahrenheit_mode,
    input  logic                            head_ready,
    output trtad_pkg::cell_t                head
);
    import trtad_pkg::*;

    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              en1;
    logic              en2;

    logic [7:0]        mag_low;
    logic [HUND_W-1:0] hund_next;
    logic [X9_W-1:0]   x9_next;

    logic [X9_W-1:0]   x9_reg;
    logic [HUND_W-1:0] hund1_reg;
    logic              neg1_reg;
    logic              fmode1_reg;

    logic [PROD_W-1:0] prod;
    logic [DISP_W-1:0] scaled_next;

    logic [DISP_W-1:0] scaled_reg;
    logic [HUND_W-1:0] hund2_reg;
    logic              neg2_reg;
    logic              fmode2_reg;

    logic [DISP_W-1:0] disp;
    logic              disp_neg;

    assign en2      = !s2_valid_reg || head_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // only magnitude bits 7..0 reach the result
    always_comb
    begin
        if (raw_reading[15])
            mag_low = ~raw_reading[12:5] + 8'd1;
        else
            mag_low = raw_reading[12:5];
        hund_next = HUND_W'(mag_low[1:0]) * HUND_W'(25)
                  + HUND_W'(mag_low[7:2]) * HUND_W'(100);
        x9_next   = {hund_next, 3'b000} + X9_W'(hund_next);
    end

    assign prod        = PROD_W'(x9_reg) * PROD_W'(RECIP5);
    assign scaled_next = prod[RECIP5_SHIFT +: DISP_W];

    always_comb
    begin
        if (fmode2_reg)
        begin
            if (!neg2_reg)
            begin
                disp     = scaled_reg + FAHR_OFFSET;
                disp_neg = 1'b0;
            end
            else if (scaled_reg <= FAHR_OFFSET)
            begin
                disp     = FAHR_OFFSET - scaled_reg;
                disp_neg = 1'b0;
            end
            else
            begin
                disp     = scaled_reg - FAHR_OFFSET;
                disp_neg = 1'b1;
            end
        end
        else
        begin
            disp     = DISP_W'(hund2_reg);
            disp_neg = neg2_reg;
        end
    end

    assign head.valid = s2_valid_reg;
    assign head.neg   = disp_neg;
    assign head.bcd   = '0;
    assign head.bin   = disp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x9_reg     <= x9_next;
            hund1_reg  <= hund_next;
            neg1_reg   <= raw_reading[15];
            fmode1_reg <= fahrenheit_mode;
        end
        if (en2)
        begin
            scaled_reg <= scaled_next;
            hund2_reg  <= hund1_reg;
            neg2_reg   <= neg1_reg;
            fmode2_reg <= fmode1_reg;
        end
    end

endmodule

/* src/trtad_cell.sv */
// ----------------------------------------------------------------------------
// trtad_cell
// One shift-and-add-3 step of the binary to BCD conversion chain.
// ----------------------------------------------------------------------------
module trtad_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  trtad_pkg::cell_t din,
    output trtad_pkg::cell_t dout
);
    import trtad_pkg::*;

    logic              valid_reg;
    logic              neg_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [DISP_W-1:0] bin_reg;

    logic [BCD_W-1:0]  adj;
    logic [BCD_W-1:0]  bcd_next;
    logic [DISP_W-1:0] bin_next;

    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (din.bcd[4*k +: 4] >= 4'd5)
                adj[4*k +: 4] = din.bcd[4*k +: 4] + 4'd3;
            else
                adj[4*k +: 4] = din.bcd[4*k +: 4];
        end
        bcd_next = {adj[BCD_W-2:0], din.bin[DISP_W-1]};
        bin_next = {din.bin[DISP_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= din.neg;
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

    assign dout.valid = valid_reg;
    assign dout.neg   = neg_reg;
    assign dout.bcd   = bcd_reg;
    assign dout.bin   = bin_reg;

endmodule

/* src/temp_reading_to_ascii_digits.sv */
// ----------------------------------------------------------------------------
// temp_reading_to_ascii_digits
// Sensor temperature word to six ASCII characters, Celsius or Fahrenheit.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  input   | in_valid / in_ready  | raw_reading[15:0]
//  output  | out_valid / out_ready| hundreds..hundredths chars, sign_hidden
//  config  | cfg_valid / cfg_ready| fahrenheit_mode
//
//  An accepted word passes two front stages (scale, multiply), then 14
//  conversion cells (one per binary bit of the displayed value) and one
//  output register before out_valid rises.
//  A word can enter every cycle unless the pipe is full and stalled.
//  Each stage moves when it is empty or the stage after it moves, so a
//  stalled output only stops input once every stage holds a word.
//  Reset clears the valid bits and selects Celsius; no clearing pass.
//
`include "temp_reading_to_ascii_digits_assert.svh"

module temp_reading_to_ascii_digits (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        fahrenheit_mode,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] raw_reading,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  hundreds_char,
    output logic [7:0]  tens_char,
    output logic [7:0]  ones_char,
    output logic [7:0]  point_char,
    output logic [7:0]  tenths_char,
    output logic [7:0]  hundredths_char,
    output logic        sign_hidden
);
    import trtad_pkg::*;

    logic  fmode_reg;

    // chain[0] is the front-end result, chain[i+1] the register of cell i
    cell_t chain [0:NUM_CELLS];
    logic  cell_en [0:NUM_CELLS];

    logic  out_en;
    logic  out_valid_reg;

    logic [3:0] d_tt;   // ten-thousands of hundredths: hundreds of degrees
    logic [3:0] d_th;   // thousands: tens of degrees
    logic [3:0] d_hu;
    logic [3:0] d_te;
    logic [3:0] d_on;

    logic [7:0] c0_next;
    logic [7:0] c1_next;
    logic       hidden_next;

    logic [7:0] c0_reg;
    logic [7:0] c1_reg;
    logic [7:0] c2_reg;
    logic [7:0] c4_reg;
    logic [7:0] c5_reg;
    logic       hidden_reg;

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmode_reg <= 1'b0;
        else if (cfg_valid)
            fmode_reg <= fahrenheit_mode;
    end

    trtad_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_reading     (raw_reading),
        .fahrenheit_mode (fmode_reg),
        .head_ready      (cell_en[0]),
        .head            (chain[0])
    );

    // stage enable ripples back from the output register
    assign out_en             = !out_valid_reg || out_ready;
    assign cell_en[NUM_CELLS] = out_en;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        assign cell_en[i] = !chain[i+1].valid || cell_en[i+1];

        trtad_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (cell_en[i]),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    assign d_tt = chain[NUM_CELLS].bcd[19:16];
    assign d_th = chain[NUM_CELLS].bcd[15:12];
    assign d_hu = chain[NUM_CELLS].bcd[11:8];
    assign d_te = chain[NUM_CELLS].bcd[7:4];
    assign d_on = chain[NUM_CELLS].bcd[3:0];

    // leading blanks; the minus sits just before the first digit shown, hidden if hundreds is nonzero
    always_comb
    begin
        c0_next     = {4'h3, d_tt};
        c1_next     = {4'h3, d_th};
        hidden_next = chain[NUM_CELLS].neg;
        if (d_tt == 4'd0)
        begin
            hidden_next = 1'b0;
            if (d_th == 4'd0)
            begin
                c0_next = CHAR_BLANK;
                c1_next = chain[NUM_CELLS].neg ? CHAR_MINUS : CHAR_BLANK;
            end
            else
            begin
                c0_next = chain[NUM_CELLS].neg ? CHAR_MINUS : CHAR_BLANK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= chain[NUM_CELLS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            c0_reg     <= c0_next;
            c1_reg     <= c1_next;
            c2_reg     <= {4'h3, d_hu};
            c4_reg     <= {4'h3, d_te};
            c5_reg     <= {4'h3, d_on};
            hidden_reg <= hidden_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hundreds_char   = c0_reg;
    assign tens_char       = c1_reg;
    assign ones_char       = c2_reg;
    assign point_char      = CHAR_POINT;
    assign tenths_char     = c4_reg;
    assign hundredths_char = c5_reg;
    assign sign_hidden     = hidden_reg;

    // input stalls only when every stage is full and the output is held
    `TRTAD_ASSERT_IMP(a_stall_full, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled with room in the pipe")
    // a hidden sign only happens with a nonzero hundreds digit
    `TRTAD_ASSERT_IMP(a_hidden_digit, clk, rst_n, out_valid && sign_hidden, hundreds_char != CHAR_BLANK && hundreds_char != CHAR_MINUS, "sign hidden without a hundreds digit")
    // ones place never blanked by the leading-zero logic
    `TRTAD_ASSERT_IMP(a_ones_digit, clk, rst_n, out_valid, ones_char >= CHAR_ZERO && ones_char <= CHAR_NINE, "ones place not a digit")
    // a word that leaves the last cell is presented next cycle
    `TRTAD_ASSERT_NXT(a_last_to_out, clk, rst_n, chain[NUM_CELLS].valid && out_en, out_valid, "word lost at output register")

endmodule

/* verif/temp_reading_to_ascii_digits_tb.sv */
// ----------------------------------------------------------------------------
// temp_reading_to_ascii_digits_tb
// Sends sensor words through the converter in Celsius and Fahrenheit and
// checks every output word against a local model of the conversion.
// ----------------------------------------------------------------------------
module temp_reading_to_ascii_digits_tb;
    import trtad_pkg::*;

    // scale select codes for the mode register
    localparam logic CELSIUS    = 1'b0;
    localparam logic FAHRENHEIT = 1'b1;

    // no handshake of any kind for this many cycles means the block is hung
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;     // settle time after the last word
    localparam int MAX_REPORTS    = 10;

    // one output word, laid out in port order
    typedef struct packed {
        logic [7:0] hundreds;
        logic [7:0] tens;
        logic [7:0] ones;
        logic [7:0] point;
        logic [7:0] tenths;
        logic [7:0] hundredths;
        logic       sign_hidden;
    } display_chars_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        fahrenheit_mode;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] raw_reading;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  hundreds_char;
    logic [7:0]  tens_char;
    logic [7:0]  ones_char;
    logic [7:0]  point_char;
    logic [7:0]  tenths_char;
    logic [7:0]  hundredths_char;
    logic        sign_hidden;

    display_chars_t expected_chars_q [$];   // predicted words, oldest first
    logic           scale_mode;             // local copy of the mode register
    logic           idle_on;                // random gaps on both channels
    int             fail_count;
    int             stall_left;
    int             quiet_cycles;

    // corner words: zero, ignored low bits, smallest step, both quarter
    // bits, 25 C, top of the six integer bits, wrap above them, largest
    // positive word, negative zero (two forms), smallest negative, -25 C,
    // and the two readings around 0 F (one stays negative, one flips)
    logic [15:0] corner_readings [0:13] = '{
        16'h0000, 16'h001F, 16'h0020, 16'h0060, 16'h0C80, 16'h1FE0, 16'h2000,
        16'h7FFF, 16'h8000, 16'hE000, 16'hFFFF, 16'hF380, 16'hF700, 16'hF720
    };

    temp_reading_to_ascii_digits u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .fahrenheit_mode (fahrenheit_mode),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_reading     (raw_reading),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hundreds_char   (hundreds_char),
        .tens_char       (tens_char),
        .ones_char       (ones_char),
        .point_char      (point_char),
        .tenths_char     (tenths_char),
        .hundredths_char (hundredths_char),
        .sign_hidden     (sign_hidden)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Conversion model: sensor word and scale -> six characters + flag
    // ------------------------------------------------------------------
    function automatic display_chars_t convert_reading(logic [15:0] raw, logic mode);
        logic           neg;
        logic [10:0]    mag;
        int unsigned    hund;
        int unsigned    scaled;
        int unsigned    disp;
        int unsigned    d0;
        int unsigned    d1;
        display_chars_t r;
        neg = raw[15];
        // 11-bit two's complement magnitude; bits 4..0 play no part
        if (neg)
            mag = ~{1'b0, raw[14:5]} + 11'd1;
        else
            mag = {1'b0, raw[14:5]};
        // only six integer bits count, so large magnitudes wrap
        hund = 25 * mag[1:0] + 100 * mag[7:2];
        if (mode == FAHRENHEIT)
        begin
            scaled = (hund * 9) / 5;
            if (!neg)
                disp = scaled + 3200;
            else if (scaled <= 3200)
            begin
                // at or above 0 F: shown positive
                disp = 3200 - scaled;
                neg  = 1'b0;
            end
            else
                disp = scaled - 3200;
        end
        else
            disp = hund;

        d0 = (disp / 10000) % 10;
        d1 = (disp / 1000) % 10;
        r.hundreds = CHAR_ZERO + 8'(d0);
        r.tens     = CHAR_ZERO + 8'(d1);
        // leading blanks, minus just before the first digit shown
        if (d0 == 0)
        begin
            if (neg)
            begin
                r.hundreds = CHAR_MINUS;
                neg        = 1'b0;
            end
            else
                r.hundreds = CHAR_BLANK;
            if (d1 == 0)
            begin
                if (r.hundreds == CHAR_MINUS)
                begin
                    r.hundreds = CHAR_BLANK;
                    r.tens     = CHAR_MINUS;
                end
                else
                    r.tens = CHAR_BLANK;
            end
        end
        r.ones        = CHAR_ZERO + 8'((disp / 100) % 10);
        r.point       = CHAR_POINT;
        r.tenths      = CHAR_ZERO + 8'((disp / 10) % 10);
        r.hundredths  = CHAR_ZERO + 8'(disp % 10);
        r.sign_hidden = neg;   // minus never placed
        return r;
    endfunction

    // mix of raw words: fully random, in-range positive, in-range negative
    function automatic logic [15:0] random_reading();
        logic [10:0] mag;
        logic [10:0] neg_field;
        mag       = 11'($urandom_range(1, 255));
        neg_field = -mag;
        case ($urandom_range(0, 3))
            0:       return {3'b000, 8'($urandom), 5'($urandom)};
            1:       return {neg_field, 5'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side. Tasks start and end just after a rising edge; in_valid
    // stays high after a send so the next send keeps it up without a dip.
    // ------------------------------------------------------------------
    task automatic send_reading(input logic [15:0] raw);
        in_valid    <= 1'b1;
        raw_reading <= raw;
        do @(posedge clk); while (!in_ready);
        expected_chars_q.push_back(convert_reading(raw, scale_mode));
    endtask

    // random sender gap, only while idle_on
    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // stop sending and wait until every predicted word has come out;
    // every word makes exactly one output, so the pipe is then empty
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (expected_chars_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_scale_mode(input logic mode);
        cfg_valid       <= 1'b1;
        fahrenheit_mode <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        scale_mode  = mode;
    endtask

    task automatic send_corner_readings();
        foreach (corner_readings[i])
        begin
            send_reading(corner_readings[i]);
            sender_gap();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // no register write yet: reset value must select Celsius
    task automatic test_celsius_after_reset();
        send_corner_readings();
    endtask

    task automatic test_fahrenheit_corners();
        wait_until_drained();
        write_scale_mode(FAHRENHEIT);
        send_corner_readings();
    endtask

    // random words in several phases; the same value is rewritten at least once
    task automatic test_random_scales();
        logic phase_mode;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       phase_mode = CELSIUS;
                1:       phase_mode = FAHRENHEIT;
                2:       phase_mode = FAHRENHEIT;
                default: phase_mode = 1'($urandom);
            endcase
            wait_until_drained();
            write_scale_mode(phase_mode);
            repeat (400)
            begin
                send_reading(random_reading());
                sender_gap();
            end
        end
    endtask

    // sender holds off until the pipe has emptied, then restarts
    task automatic test_sender_pause();
        for (int burst = 0; burst < 5; burst++)
        begin
            repeat (24)
            begin
                send_reading(random_reading());
                sender_gap();
            end
            wait_until_drained();
        end
    endtask

    // full rate, no gaps on either side
    task automatic test_back_to_back();
        wait_until_drained();
        write_scale_mode(1'($urandom));
        idle_on = 1'b0;
        repeat (200) send_reading(random_reading());
        in_valid <= 1'b0;
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        fahrenheit_mode = CELSIUS;
        in_valid        = 1'b0;
        raw_reading     = '0;
        scale_mode      = CELSIUS;
        idle_on         = 1'b1;
        fail_count      = 0;
        stall_left      = 0;
        quiet_cycles    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_celsius_after_reset();
        test_fahrenheit_corners();
        test_random_scales();
        test_sender_pause();
        test_back_to_back();

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random stall bursts while idle_on
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Checker: each output word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        display_chars_t want;
        display_chars_t got;
        logic           bad;
        if (rst_n && out_valid && out_ready)
        begin
            got = {hundreds_char, tens_char, ones_char, point_char,
                   tenths_char, hundredths_char, sign_hidden};
            if (expected_chars_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected output word \"%s\" hidden %b",
                             got[48:1], got.sign_hidden);
            end
            else
            begin
                want = expected_chars_q.pop_front();
                bad  = (got.hundreds    !== want.hundreds)    ||
                       (got.tens        !== want.tens)        ||
                       (got.ones        !== want.ones)        ||
                       (got.point       !== want.point)       ||
                       (got.tenths      !== want.tenths)      ||
                       (got.hundredths  !== want.hundredths)  ||
                       (got.sign_hidden !== want.sign_hidden);
                if (bad)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: expected \"%s\" hidden %b, got \"%s\" hidden %b",
                                 want[48:1], want.sign_hidden, got[48:1], got.sign_hidden);
                end
            end
        end
    end

    // watchdog: counts cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
